### sv/color_invariant_pixel_converter_macros.svh
// ----------------------------------------------------------------------------
// Color invariant pixel converter assertion macros
// Shared concurrent assertion forms for the converter checks.
// ----------------------------------------------------------------------------
`ifndef COLOR_INVARIANT_PIXEL_CONVERTER_MACROS_SVH
`define COLOR_INVARIANT_PIXEL_CONVERTER_MACROS_SVH

`define CICV_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("check failed");

`define CICV_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("check failed");

`define CICV_ASSERT_RESET(label, clk, pre, post) \
   label: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("check failed");

`endif

### sv/cicv_pkg.sv
// ----------------------------------------------------------------------------
// Color invariant pixel converter package
// Types, widths and the arctangent table shared by the converter modules.
// ----------------------------------------------------------------------------
package cicv_pkg;

   localparam int CordicSteps = 16;
   localparam int CoreDepth = CordicSteps + 1;
   localparam int DivSteps = 8;
   localparam int RemW = 26;
   localparam int DvsW = 18;
   localparam int XyW = 27;
   localparam int ZW = 19;
   localparam int FracW = 16;

   localparam logic [15:0] LumaWeightR = 16'd19595;
   localparam logic [15:0] LumaWeightG = 16'd38470;
   localparam logic [15:0] LumaWeightB = 16'd7471;

   typedef enum logic [1:0] {
      MODE_NORM    = 2'd0,
      MODE_LUMA    = 2'd1,
      MODE_C1C2C3  = 2'd2,
      MODE_L1L2L3  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [7:0] blue_in;
      logic [7:0] green_in;
      logic [7:0] red_in;
   } pixel_in_type;

   typedef struct packed {
      logic [7:0] out_slot0;
      logic [7:0] out_slot1;
      logic [7:0] out_slot2;
   } pixel_out_type;

   typedef struct packed {
      logic [RemW-1:0]       rem;
      logic [DvsW-1:0]       dvs;
      logic [DivSteps-1:0]   quo;
      logic signed [XyW-1:0] x;
      logic signed [XyW-1:0] y;
      logic signed [ZW-1:0]  z;
      logic                  force_zero;
      logic                  force_full;
   } lane_type;

   typedef struct packed {
      lane_type [2:0] lane;
      logic [7:0]     luma;
      mode_type       mode;
   } stage_type;

   function automatic logic signed [ZW-1:0] atan_angle(input logic [3:0] idx);
      logic signed [ZW-1:0] a;
      unique case (idx)
         4'd0:    a = 19'sd51472;
         4'd1:    a = 19'sd30386;
         4'd2:    a = 19'sd16055;
         4'd3:    a = 19'sd8150;
         4'd4:    a = 19'sd4091;
         4'd5:    a = 19'sd2047;
         4'd6:    a = 19'sd1024;
         4'd7:    a = 19'sd512;
         4'd8:    a = 19'sd256;
         4'd9:    a = 19'sd128;
         4'd10:   a = 19'sd64;
         4'd11:   a = 19'sd32;
         4'd12:   a = 19'sd16;
         4'd13:   a = 19'sd8;
         4'd14:   a = 19'sd4;
         default: a = 19'sd2;
      endcase
      return a;
   endfunction

endpackage

### sv/cicv_prep.sv
// ----------------------------------------------------------------------------
// Color invariant pixel converter front end
// Forms dividends, divisors, rotation start vectors and luma for one pixel.
// ----------------------------------------------------------------------------
module cicv_prep (
   input  cicv_pkg::pixel_in_type pixel,
   input  cicv_pkg::mode_type     mode,
   output cicv_pkg::stage_type    prep
);

   function automatic logic [16:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] d;
      d = (a >= b) ? a - b : b - a;
      return {1'b0, 16'(d) * 16'(d)};
   endfunction

   function automatic cicv_pkg::lane_type make_lane(
      input cicv_pkg::mode_type mode_v,
      input logic [16:0] num, input logic [16:0] den,
      input logic [7:0] cn, input logic [7:0] cd
   );
      cicv_pkg::lane_type l;
      l.rem = (cicv_pkg::RemW'(num) << 9) - (cicv_pkg::RemW'(num) << 1)
            + cicv_pkg::RemW'(den);
      l.dvs = {den, 1'b0};
      l.quo = '0;
      l.x = cicv_pkg::XyW'({cd, 16'd0});
      l.y = cicv_pkg::XyW'({cn, 16'd0});
      l.z = '0;
      if (mode_v == cicv_pkg::MODE_C1C2C3) begin
         l.force_zero = (cn == 8'd0);
         l.force_full = (cn != 8'd0) && (cd == 8'd0);
      end else begin
         l.force_zero = (den == 17'd0);
         l.force_full = 1'b0;
      end
      return l;
   endfunction

   logic [7:0]  b, g, r;
   logic [16:0] sum, sq_rg, sq_rb, sq_gb, tot;
   logic [23:0] luma_acc;
   logic [7:0]  max_rg, max_rb, max_gb;
   logic        sq_mode;

   always_comb begin
      b = pixel.blue_in;
      g = pixel.green_in;
      r = pixel.red_in;
      sum = 17'(b) + 17'(g) + 17'(r);
      sq_rg = sq_diff(r, g);
      sq_rb = sq_diff(r, b);
      sq_gb = sq_diff(g, b);
      tot = sq_rg + sq_rb + sq_gb;
      luma_acc = 24'(cicv_pkg::LumaWeightR) * 24'(r) + 24'(cicv_pkg::LumaWeightG) * 24'(g)
               + 24'(cicv_pkg::LumaWeightB) * 24'(b);
      max_rg = (r >= g) ? r : g;
      max_rb = (r >= b) ? r : b;
      max_gb = (g >= b) ? g : b;
      sq_mode = (mode == cicv_pkg::MODE_L1L2L3);
      prep.mode = mode;
      prep.luma = luma_acc[23:16];
      prep.lane[0] = make_lane(mode, sq_mode ? sq_gb : 17'(b), sq_mode ? tot : sum,
                               b, max_rg);
      prep.lane[1] = make_lane(mode, sq_mode ? sq_rb : 17'(g), sq_mode ? tot : sum,
                               g, max_rb);
      prep.lane[2] = make_lane(mode, sq_mode ? sq_rg : 17'(r), sq_mode ? tot : sum,
                               r, max_gb);
   end

endmodule

### sv/cicv_core.sv
// ----------------------------------------------------------------------------
// Color invariant pixel converter iteration pipeline
// Sixteen registered stages; each runs one rotation step on every lane and,
// in the first eight, one restoring division bit.
// ----------------------------------------------------------------------------
module cicv_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  cicv_pkg::stage_type in_stage,
   output logic                out_valid,
   output cicv_pkg::stage_type out_stage
);

   cicv_pkg::stage_type stage_ff [cicv_pkg::CoreDepth];
   cicv_pkg::stage_type stage_in [cicv_pkg::CoreDepth];
   logic                valid_ff [cicv_pkg::CoreDepth];

   assign stage_in[0] = in_stage;

   for (genvar k = 0; k < cicv_pkg::CordicSteps; k++) begin : g_step
      always_comb begin
         cicv_pkg::stage_type s;
         logic signed [cicv_pkg::XyW-1:0] xs, ys;
         logic signed [cicv_pkg::ZW-1:0] ang;
         logic [cicv_pkg::RemW-1:0] sub;
         s = stage_ff[k];
         ang = cicv_pkg::atan_angle(4'(k));
         for (int j = 0; j < 3; j++) begin
            xs = stage_ff[k].lane[j].x >>> k;
            ys = stage_ff[k].lane[j].y >>> k;
            if (!stage_ff[k].lane[j].y[cicv_pkg::XyW-1]) begin
               s.lane[j].x = stage_ff[k].lane[j].x + ys;
               s.lane[j].y = stage_ff[k].lane[j].y - xs;
               s.lane[j].z = stage_ff[k].lane[j].z + ang;
            end else begin
               s.lane[j].x = stage_ff[k].lane[j].x - ys;
               s.lane[j].y = stage_ff[k].lane[j].y + xs;
               s.lane[j].z = stage_ff[k].lane[j].z - ang;
            end
            sub = '0;
            if (k < cicv_pkg::DivSteps) begin
               sub = cicv_pkg::RemW'(stage_ff[k].lane[j].dvs)
                     << (cicv_pkg::DivSteps - 1 - (k % cicv_pkg::DivSteps));
               if (stage_ff[k].lane[j].rem >= sub) begin
                  s.lane[j].rem = stage_ff[k].lane[j].rem - sub;
                  s.lane[j].quo[cicv_pkg::DivSteps - 1 - (k % cicv_pkg::DivSteps)] = 1'b1;
               end
            end
         end
         stage_in[k + 1] = s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < cicv_pkg::CoreDepth; k++) valid_ff[k] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < cicv_pkg::CoreDepth; k++) valid_ff[k] <= valid_ff[k - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < cicv_pkg::CoreDepth; k++) stage_ff[k] <= stage_in[k];
      end
   end

   assign out_valid = valid_ff[cicv_pkg::CoreDepth - 1];
   assign out_stage = stage_ff[cicv_pkg::CoreDepth - 1];

endmodule

### sv/cicv_post.sv
// ----------------------------------------------------------------------------
// Color invariant pixel converter back end
// Scales angles, applies special cases and picks each output slot.
// ----------------------------------------------------------------------------
module cicv_post (
   input  cicv_pkg::stage_type     fin,
   output cicv_pkg::pixel_out_type pixel
);

   function automatic logic [7:0] lane_result(input cicv_pkg::mode_type mode,
                                              input cicv_pkg::lane_type l);
      logic signed [28:0] p;
      logic signed [28:0] t;
      logic [7:0] v;
      p = (29'(l.z) <<< 8) - 29'(l.z) + 29'sd32768;
      t = p >>> cicv_pkg::FracW;
      if (l.force_zero) begin
         v = 8'd0;
      end else if (l.force_full) begin
         v = 8'd255;
      end else if (mode == cicv_pkg::MODE_C1C2C3) begin
         if (p < 0) v = 8'd0;
         else if (t > 29'sd255) v = 8'd255;
         else v = t[7:0];
      end else begin
         v = l.quo;
      end
      return v;
   endfunction

   always_comb begin
      pixel.out_slot0 = (fin.mode == cicv_pkg::MODE_LUMA) ? fin.luma
                                                         : lane_result(fin.mode, fin.lane[0]);
      pixel.out_slot1 = lane_result(fin.mode, fin.lane[1]);
      pixel.out_slot2 = lane_result(fin.mode, fin.lane[2]);
   end

endmodule

### sv/color_invariant_pixel_converter.sv
// ----------------------------------------------------------------------------
// Color invariant pixel converter
// The pipeline holds one front-end register, sixteen rotation stages and
// one output register. One pixel is taken every cycle while the result side
// takes results; the rotation pipeline depth sets the latency.
// Synchronous reset empties every stage and sets the mode to normalized RGB.
// ----------------------------------------------------------------------------
`include "color_invariant_pixel_converter_macros.svh"

module color_invariant_pixel_converter (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  cicv_pkg::pixel_in_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output cicv_pkg::pixel_out_type rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_data
);

   cicv_pkg::mode_type      mode_ff;
   cicv_pkg::stage_type     prep;
   cicv_pkg::stage_type     core_stage;
   cicv_pkg::pixel_out_type rsp_data_in;
   cicv_pkg::pixel_out_type rsp_data_ff;
   logic                    rsp_valid_ff;
   logic                    core_valid;
   logic                    advance;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= cicv_pkg::MODE_NORM;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= cicv_pkg::mode_type'(csr_data);
      end
   end

   cicv_prep u_prep (
      .pixel (req_data),
      .mode  (mode_ff),
      .prep  (prep)
   );

   cicv_core u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_stage  (prep),
      .out_valid (core_valid),
      .out_stage (core_stage)
   );

   cicv_post u_post (
      .fin   (core_stage),
      .pixel (rsp_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= core_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   `CICV_ASSERT_SAME(a_stall_holds_input, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `CICV_ASSERT_NEXT(a_mode_only_by_csr, clock, reset, !(csr_valid && csr_ready), $stable(mode_ff))
   `CICV_ASSERT_RESET(a_empty_after_reset, clock, reset, !rsp_valid)

endmodule
